>>> design/dpm_pkg.sv
package dpm_pkg;

   localparam int unsigned VAL_BITS = 64;
   localparam int unsigned DEG_BITS = 16;
   localparam int unsigned IDX_BITS = 2;
   localparam int unsigned DEF_WIDTH = 64;
   localparam int unsigned DEF_DEGREE_BITS = 16;

   typedef enum logic [IDX_BITS-1:0] {
      REG_MODULUS    = 2'd0,
      REG_POLY_PARAM = 2'd1,
      REG_DEGREE     = 2'd2
   } dpm_reg_type;

   // multiplier operand sources
   typedef enum logic [3:0] {
      SRC_ONE, SRC_XRAW, SRC_ARAW, SRC_X, SRC_A, SRC_T, SRC_R, SRC_PW, SRC_BASE
   } dpm_src_type;

   // datapath register updates
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_WB_X, OP_WB_A, OP_STRIP, OP_WB_R0, OP_WB_U, OP_WB_RI,
      OP_POW_INIT, OP_WB_PW, OP_WB_BASE, OP_WB_D, OP_WB_PWSQ, OP_FINISH
   } dpm_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_XRED, ST_ARED, ST_STRIP, ST_SQX, ST_LOOP, ST_MTA, ST_MRX,
      ST_POWI, ST_PCHK, ST_PMUL, ST_PSQ, ST_DCHK, ST_DMUL, ST_DSQ, ST_DONE
   } dpm_state_type;

   typedef struct packed {
      dpm_op_type  op;
      logic        mul_start;
      dpm_src_type src_a;
      dpm_src_type src_b;
   } dpm_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic p_lt2;
      logic n_le1;
      logic n_even_gt2;
      logic i_lt_n;
      logic e_zero;
      logic e_lsb;
      logic b_zero;
   } dpm_status_type;

endpackage

>>> design/dpm_ctrl.sv
module dpm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  dpm_pkg::dpm_status_type st,
   output dpm_pkg::dpm_cmd_type    cmd
);
   import dpm_pkg::*;

   dpm_state_type state_ff, state_in;
   logic          launched_ff, launched_in;
   logic          is_mul;
   dpm_src_type   sa, sb;
   dpm_op_type    wb_op;
   dpm_state_type mul_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         launched_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      launched_in   = launched_ff;
      cmd.op        = OP_NONE;
      cmd.mul_start = 1'b0;
      is_mul        = 1'b0;
      sa            = SRC_ONE;
      sb            = SRC_ONE;
      wb_op         = OP_NONE;
      mul_next      = ST_IDLE;
      busy          = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = ST_XRED;
            end
         end
         ST_XRED: begin
            is_mul = 1'b1; sa = SRC_ONE; sb = SRC_XRAW; wb_op = OP_WB_X;
            mul_next = (st.p_lt2 || st.n_le1) ? ST_DONE : ST_ARED;
         end
         ST_ARED: begin
            is_mul = 1'b1; sa = SRC_ONE; sb = SRC_ARAW; wb_op = OP_WB_A;
            mul_next = ST_STRIP;
         end
         ST_STRIP: begin
            if (st.n_even_gt2) cmd.op = OP_STRIP;
            else state_in = ST_SQX;
         end
         ST_SQX: begin
            is_mul = 1'b1; sa = SRC_X; sb = SRC_X; wb_op = OP_WB_R0;
            mul_next = ST_LOOP;
         end
         ST_LOOP: begin
            state_in = st.i_lt_n ? ST_MTA : ST_POWI;
         end
         ST_MTA: begin
            is_mul = 1'b1; sa = SRC_T; sb = SRC_A; wb_op = OP_WB_U;
            mul_next = ST_MRX;
         end
         ST_MRX: begin
            is_mul = 1'b1; sa = SRC_R; sb = SRC_X; wb_op = OP_WB_RI;
            mul_next = ST_LOOP;
         end
         ST_POWI: begin
            cmd.op   = OP_POW_INIT;
            state_in = ST_PCHK;
         end
         ST_PCHK: begin
            priority if (st.e_zero) state_in = ST_DCHK;
            else if (st.e_lsb)      state_in = ST_PMUL;
            else                    state_in = ST_PSQ;
         end
         ST_PMUL: begin
            is_mul = 1'b1; sa = SRC_PW; sb = SRC_BASE; wb_op = OP_WB_PW;
            mul_next = ST_PSQ;
         end
         ST_PSQ: begin
            is_mul = 1'b1; sa = SRC_BASE; sb = SRC_BASE; wb_op = OP_WB_BASE;
            mul_next = ST_PCHK;
         end
         ST_DCHK: begin
            state_in = st.b_zero ? ST_DONE : ST_DMUL;
         end
         ST_DMUL: begin
            is_mul = 1'b1; sa = SRC_R; sb = SRC_R; wb_op = OP_WB_D;
            mul_next = ST_DSQ;
         end
         ST_DSQ: begin
            is_mul = 1'b1; sa = SRC_PW; sb = SRC_PW; wb_op = OP_WB_PWSQ;
            mul_next = ST_DCHK;
         end
         ST_DONE: begin
            cmd.op   = OP_FINISH;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      cmd.src_a = sa;
      cmd.src_b = sb;
      // each multiply state launches once, then waits for the done pulse
      if (is_mul) begin
         if (!launched_ff) begin
            cmd.mul_start = 1'b1;
            launched_in   = 1'b1;
         end else if (st.mul_done) begin
            cmd.op      = wb_op;
            launched_in = 1'b0;
            state_in    = mul_next;
         end
      end
   end

endmodule

>>> design/dpm_datapath.sv
module dpm_datapath #(
   parameter int unsigned WIDTH       = 64,
   parameter int unsigned DEGREE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dpm_pkg::IDX_BITS-1:0]    csr_index,
   input  logic [dpm_pkg::VAL_BITS-1:0]    csr_wdata,
   input  logic [dpm_pkg::VAL_BITS-1:0]    req_point,
   input  dpm_pkg::dpm_cmd_type            cmd,
   output dpm_pkg::dpm_status_type         st,
   output logic                            rsp_valid,
   output logic [dpm_pkg::VAL_BITS-1:0]    rsp_value
);
   import dpm_pkg::*;

   localparam int unsigned NB = (DEGREE_BITS < DEG_BITS) ? DEGREE_BITS : DEG_BITS;
   localparam int unsigned BW = $clog2(NB) + 1;
   localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] p);
      logic [WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, p}) s = s - {1'b0, p};
      return s[WIDTH-1:0];
   endfunction

   function automatic logic [WIDTH-1:0] sub_mod(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] p);
      return (a >= b) ? (a - b) : (a - b + p);
   endfunction

   logic [VAL_BITS-1:0] modulus_ff, param_ff;
   logic [DEG_BITS-1:0] degree_ff;

   logic [WIDTH-1:0] p_ff, xraw_ff, araw_ff, x_ff, a_ff, r_ff, t_ff, u_ff, pw_ff, base_ff;
   logic [NB-1:0]    n_ff, i_ff, e_ff;
   logic [BW-1:0]    b_ff;
   logic [WIDTH-1:0] ma_ff, mb_ff, acc_ff, acc_in, dbl, src_a, src_b;
   logic [CW-1:0]    cnt_ff;
   logic             mul_busy_ff, mul_done_ff, rsp_valid_ff;
   logic [WIDTH-1:0] rsp_value_ff;

   function automatic logic [WIDTH-1:0] pick(input dpm_src_type s,
                                             input logic [WIDTH-1:0] xr,
                                             input logic [WIDTH-1:0] ar,
                                             input logic [WIDTH-1:0] x,
                                             input logic [WIDTH-1:0] a,
                                             input logic [WIDTH-1:0] t,
                                             input logic [WIDTH-1:0] r,
                                             input logic [WIDTH-1:0] pw,
                                             input logic [WIDTH-1:0] bs);
      logic [WIDTH-1:0] v;
      unique case (s)
         SRC_ONE:  v = WIDTH'(1);
         SRC_XRAW: v = xr;
         SRC_ARAW: v = ar;
         SRC_X:    v = x;
         SRC_A:    v = a;
         SRC_T:    v = t;
         SRC_R:    v = r;
         SRC_PW:   v = pw;
         SRC_BASE: v = bs;
         default:  v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      src_a = pick(cmd.src_a, xraw_ff, araw_ff, x_ff, a_ff, t_ff, r_ff, pw_ff, base_ff);
      src_b = pick(cmd.src_b, xraw_ff, araw_ff, x_ff, a_ff, t_ff, r_ff, pw_ff, base_ff);
      // one multiplier bit per cycle, msb first: acc = 2*acc + bit*a
      dbl    = add_mod(acc_ff, acc_ff, p_ff);
      acc_in = mb_ff[WIDTH-1] ? add_mod(dbl, ma_ff, p_ff) : dbl;
   end

   always_comb begin
      st.mul_done   = mul_done_ff;
      st.p_lt2      = (p_ff < WIDTH'(2));
      st.n_le1      = (n_ff < NB'(2));
      st.n_even_gt2 = (n_ff > NB'(2)) && !n_ff[0];
      st.i_lt_n     = (i_ff < n_ff);
      st.e_zero     = (e_ff == '0);
      st.e_lsb      = e_ff[0];
      st.b_zero     = (b_ff == '0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= VAL_BITS'(2);
         param_ff     <= '0;
         degree_ff    <= DEG_BITS'(2);
         mul_busy_ff  <= 1'b0;
         mul_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_MODULUS:    modulus_ff <= csr_wdata;
               REG_POLY_PARAM: param_ff   <= csr_wdata;
               REG_DEGREE:     degree_ff  <= csr_wdata[DEG_BITS-1:0];
               default: ;
            endcase
         end
         mul_done_ff  <= 1'b0;
         rsp_valid_ff <= (cmd.op == OP_FINISH);
         if (cmd.mul_start) begin
            mul_busy_ff <= 1'b1;
         end else if (mul_busy_ff && cnt_ff == '0) begin
            mul_busy_ff <= 1'b0;
            mul_done_ff <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         ma_ff  <= src_a;
         mb_ff  <= src_b;
         acc_ff <= '0;
         cnt_ff <= CW'(WIDTH - 1);
      end else if (mul_busy_ff) begin
         acc_ff <= acc_in;
         mb_ff  <= {mb_ff[WIDTH-2:0], 1'b0};
         cnt_ff <= cnt_ff - CW'(1);
      end

      unique case (cmd.op)
         OP_NONE: ;
         OP_LOAD: begin
            p_ff    <= modulus_ff[WIDTH-1:0];
            araw_ff <= param_ff[WIDTH-1:0];
            xraw_ff <= req_point[WIDTH-1:0];
            n_ff    <= degree_ff[NB-1:0];
            b_ff    <= '0;
         end
         OP_WB_X:  x_ff <= acc_ff;
         OP_WB_A:  a_ff <= acc_ff;
         OP_STRIP: begin
            n_ff <= n_ff >> 1;
            b_ff <= b_ff + BW'(1);
         end
         OP_WB_R0: begin
            r_ff <= sub_mod(acc_ff, add_mod(a_ff, a_ff, p_ff), p_ff);
            t_ff <= x_ff;
            i_ff <= NB'(2);
         end
         OP_WB_U:  u_ff <= acc_ff;
         OP_WB_RI: begin
            t_ff <= r_ff;
            r_ff <= sub_mod(acc_ff, u_ff, p_ff);
            i_ff <= i_ff + NB'(1);
         end
         OP_POW_INIT: begin
            pw_ff   <= WIDTH'(1);
            base_ff <= a_ff;
            e_ff    <= n_ff;
         end
         OP_WB_PW:   pw_ff <= acc_ff;
         OP_WB_BASE: begin
            base_ff <= acc_ff;
            e_ff    <= e_ff >> 1;
         end
         OP_WB_D:    r_ff <= sub_mod(acc_ff, add_mod(pw_ff, pw_ff, p_ff), p_ff);
         OP_WB_PWSQ: begin
            pw_ff <= acc_ff;
            b_ff  <= b_ff - BW'(1);
         end
         OP_FINISH: begin
            priority if (p_ff < WIDTH'(2)) rsp_value_ff <= '0;
            else if (n_ff == '0)           rsp_value_ff <= WIDTH'(1);
            else if (n_ff == NB'(1))       rsp_value_ff <= x_ff;
            else                           rsp_value_ff <= r_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = VAL_BITS'(rsp_value_ff);

endmodule

>>> design/dickson_polynomial_mod.sv
// channel   ports                                   handshake
// request   start, busy, req_point                  taken when start && !busy
// response  rsp_valid, rsp_value                    one-cycle strobe, no backpressure
// csr       csr_we, csr_index, csr_wdata            written when csr_we
//
// one word at a time; a shared bit-serial modular multiplier computes every product.
// an item costs 3 + 2*(m-2) + bitlen(m) + popcount(m) + 2*k products,
// where n = m * 2^k and m is the odd part of n, or 2 when n is a power of two;
// degree 0 or 1 or a modulus below two costs one product. synchronous
// active-high reset restores modulus 2, parameter 0, degree 2.
// the receiver cannot stall; busy falls as the result strobe rises.
module dickson_polynomial_mod #(
   parameter int unsigned WIDTH       = dpm_pkg::DEF_WIDTH,
   parameter int unsigned DEGREE_BITS = dpm_pkg::DEF_DEGREE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dpm_pkg::VAL_BITS-1:0]  req_point,
   output logic                          rsp_valid,
   output logic [dpm_pkg::VAL_BITS-1:0]  rsp_value,
   input  logic                          csr_we,
   input  logic [dpm_pkg::IDX_BITS-1:0]  csr_index,
   input  logic [dpm_pkg::VAL_BITS-1:0]  csr_wdata
);
   import dpm_pkg::*;

   dpm_cmd_type    cmd;
   dpm_status_type st;

   dpm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   dpm_datapath #(
      .WIDTH       (WIDTH),
      .DEGREE_BITS (DEGREE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_point (req_point),
      .cmd       (cmd),
      .st        (st),
      .rsp_valid (rsp_valid),
      .rsp_value (rsp_value)
   );

endmodule
